FILE: rtl/core/hsfcd_pkg.sv
// Shared types and constants for the header-synchronized frame deframer.
`timescale 1ns / 1ps
`default_nettype none

package hsfcd_pkg;

    localparam int FRAME_LEN_DEFAULT = 32;
    localparam int BYTE_W            = 8;
    localparam int POS_W             = 5;
    localparam int SUM_W             = 16;
    localparam int HDR_LEN           = 3;

    localparam logic [BYTE_W-1:0] HDR0 = 8'h53;
    localparam logic [BYTE_W-1:0] HDR1 = 8'h44;
    localparam logic [BYTE_W-1:0] HDR2 = 8'h52;

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_READ,
        ST_SHOW,
        ST_FAIL
    } state_t;

    typedef struct packed {
        logic accept;
        logic rd_start;
        logic rd_issue;
        logic rd_advance;
        logic show;
    } ctrl_cmd_t;

    typedef struct packed {
        logic frame_done;
        logic sum_match;
        logic rd_last;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/hsfcd_datapath.sv
// Datapath: frame store, position counter, checksum and replay read port.
`timescale 1ns / 1ps
`default_nettype none

module hsfcd_datapath #(
    parameter int FRAME_LEN = hsfcd_pkg::FRAME_LEN_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire hsfcd_pkg::ctrl_cmd_t          cmd,
    output hsfcd_pkg::dp_status_t              status,
    input  wire logic [hsfcd_pkg::BYTE_W-1:0]  rx_byte,
    output logic [hsfcd_pkg::BYTE_W-1:0]       frame_byte,
    output logic [hsfcd_pkg::POS_W-1:0]        byte_position,
    output logic                               last,
    output logic                               checksum_ok,
    output logic [hsfcd_pkg::SUM_W-1:0]        computed_sum
);

    localparam int CW = $clog2(FRAME_LEN);
    localparam logic [CW-1:0] POS_LAST    = CW'(FRAME_LEN - 1);
    localparam logic [CW-1:0] POS_TRAIL   = CW'(FRAME_LEN - 2);
    localparam logic [CW-1:0] POS_SUM_END = CW'(FRAME_LEN - 3);
    localparam logic [CW-1:0] POS_SUM_BEG = CW'(hsfcd_pkg::HDR_LEN);
    localparam logic [CW-1:0] POS_HDR1    = CW'(1);
    localparam logic [CW-1:0] POS_HDR2    = CW'(2);

    logic [hsfcd_pkg::BYTE_W-1:0] mem [FRAME_LEN];

    logic [CW-1:0]                pos_reg;
    logic [CW-1:0]                pos_next;
    logic [hsfcd_pkg::SUM_W-1:0]  sum_reg;
    logic [hsfcd_pkg::SUM_W-1:0]  sum_next;
    logic                         hdr1_ok_reg;
    logic                         hdr1_ok_next;
    logic [hsfcd_pkg::BYTE_W-1:0] trail_hi_reg;
    logic [hsfcd_pkg::BYTE_W-1:0] trail_hi_next;
    logic [CW-1:0]                rd_addr_reg;
    logic [CW-1:0]                rd_addr_next;
    logic [hsfcd_pkg::BYTE_W-1:0] rdata_reg;

    always_comb
    begin
        pos_next      = pos_reg;
        sum_next      = sum_reg;
        hdr1_ok_next  = hdr1_ok_reg;
        trail_hi_next = trail_hi_reg;
        if (cmd.accept)
        begin
            if (pos_reg == '0)
            begin
                if (rx_byte == hsfcd_pkg::HDR0)
                begin
                    sum_next = '0;
                    pos_next = CW'(1);
                end
            end
            else
            begin
                if (pos_reg >= POS_SUM_BEG && pos_reg <= POS_SUM_END)
                begin
                    sum_next = sum_reg + {{(hsfcd_pkg::SUM_W - hsfcd_pkg::BYTE_W){1'b0}},
                                          rx_byte};
                end
                if (pos_reg == POS_HDR1)
                begin
                    hdr1_ok_next = (rx_byte == hsfcd_pkg::HDR1);
                end
                if (pos_reg == POS_TRAIL)
                begin
                    trail_hi_next = rx_byte;
                end
                if (pos_reg == POS_HDR2 && !(hdr1_ok_reg && rx_byte == hsfcd_pkg::HDR2))
                begin
                    pos_next = '0;
                end
                else if (pos_reg == POS_LAST)
                begin
                    pos_next = '0;
                end
                else
                begin
                    pos_next = pos_reg + CW'(1);
                end
            end
        end
    end

    always_comb
    begin
        rd_addr_next = rd_addr_reg;
        if (cmd.rd_start)
        begin
            rd_addr_next = '0;
        end
        else if (cmd.rd_advance)
        begin
            rd_addr_next = rd_addr_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            sum_reg     <= '0;
            hdr1_ok_reg <= 1'b0;
            rd_addr_reg <= '0;
        end
        else
        begin
            pos_reg     <= pos_next;
            sum_reg     <= sum_next;
            hdr1_ok_reg <= hdr1_ok_next;
            rd_addr_reg <= rd_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        trail_hi_reg <= trail_hi_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mem[pos_reg] <= rx_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_issue)
        begin
            rdata_reg <= mem[rd_addr_reg];
        end
    end

    assign status.frame_done = (pos_reg == POS_LAST);
    assign status.sum_match  = ({trail_hi_reg, rx_byte} == sum_reg);
    assign status.rd_last    = (rd_addr_reg == POS_LAST);

    assign frame_byte    = cmd.show ? rdata_reg : '0;
    assign byte_position = cmd.show ? hsfcd_pkg::POS_W'(rd_addr_reg) : '0;
    assign last          = cmd.show ? status.rd_last : 1'b1;
    assign checksum_ok   = cmd.show;
    assign computed_sum  = sum_reg;

endmodule

`default_nettype wire

FILE: rtl/core/hsfcd_ctrl.sv
// Controller: sequences collection, checksum verdict and frame replay.
`timescale 1ns / 1ps
`default_nettype none

module hsfcd_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    input  wire hsfcd_pkg::dp_status_t  status,
    output hsfcd_pkg::ctrl_cmd_t        cmd
);

    hsfcd_pkg::state_t state_reg;
    hsfcd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hsfcd_pkg::ST_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid      = 1'b0;
        case (state_reg)
            hsfcd_pkg::ST_COLLECT:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && status.frame_done)
                begin
                    if (status.sum_match)
                    begin
                        cmd.rd_start = 1'b1;
                        state_next   = hsfcd_pkg::ST_READ;
                    end
                    else
                    begin
                        state_next = hsfcd_pkg::ST_FAIL;
                    end
                end
            end
            hsfcd_pkg::ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = hsfcd_pkg::ST_SHOW;
            end
            hsfcd_pkg::ST_SHOW:
            begin
                out_valid = 1'b1;
                cmd.show  = 1'b1;
                if (out_ready)
                begin
                    if (status.rd_last)
                    begin
                        state_next = hsfcd_pkg::ST_COLLECT;
                    end
                    else
                    begin
                        cmd.rd_advance = 1'b1;
                        state_next     = hsfcd_pkg::ST_READ;
                    end
                end
            end
            hsfcd_pkg::ST_FAIL:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = hsfcd_pkg::ST_COLLECT;
                end
            end
            default:
            begin
                state_next = hsfcd_pkg::ST_COLLECT;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/header_sync_frame_checksum_deframer_top.sv
// Bytes are taken at one per cycle while collecting. A failure item is offered in the cycle
// after the transaction that completes a frame; a good frame is replayed byte by byte, each byte
// read from the frame store into a register in ST_READ, then offered in ST_SHOW until taken; the
// failure item is held until taken. Input is not taken while results are pending. Reset clears
// the controller, position counter and checksum; the frame store is not cleared, as every entry
// is written before it is read.
`timescale 1ns / 1ps
`default_nettype none

module header_sync_frame_checksum_deframer_top #(
    parameter int FRAME_LEN = hsfcd_pkg::FRAME_LEN_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [hsfcd_pkg::BYTE_W-1:0]  rx_byte,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [hsfcd_pkg::BYTE_W-1:0]       frame_byte,
    output logic [hsfcd_pkg::POS_W-1:0]        byte_position,
    output logic                               last,
    output logic                               checksum_ok,
    output logic [hsfcd_pkg::SUM_W-1:0]        computed_sum
);

    hsfcd_pkg::ctrl_cmd_t  cmd;
    hsfcd_pkg::dp_status_t status;

    hsfcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    hsfcd_datapath #(
        .FRAME_LEN (FRAME_LEN)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .rx_byte       (rx_byte),
        .frame_byte    (frame_byte),
        .byte_position (byte_position),
        .last          (last),
        .checksum_ok   (checksum_ok),
        .computed_sum  (computed_sum)
    );

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for the header-synchronized frame deframer driven with framed byte streams.
`timescale 1ns / 1ps

module tb_top;

    localparam int FRAME_LEN    = hsfcd_pkg::FRAME_LEN_DEFAULT;
    localparam int BYTE_W       = hsfcd_pkg::BYTE_W;
    localparam int POS_W        = hsfcd_pkg::POS_W;
    localparam int SUM_W        = hsfcd_pkg::SUM_W;
    localparam int HDR_LEN      = hsfcd_pkg::HDR_LEN;
    localparam logic [BYTE_W-1:0] HDR0 = hsfcd_pkg::HDR0;
    localparam logic [BYTE_W-1:0] HDR1 = hsfcd_pkg::HDR1;
    localparam logic [BYTE_W-1:0] HDR2 = hsfcd_pkg::HDR2;
    localparam int SUM_LO       = HDR_LEN;
    localparam int SUM_HI       = FRAME_LEN - 3;
    localparam int RANDOM_ITEMS = 355;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 600;
    localparam int TAIL_CYCLES  = 2 * FRAME_LEN + 16;

    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES
    } fill_t;

    typedef struct {
        logic [BYTE_W-1:0] data;
        bit                drain;
        bit                hold;
    } rx_item_t;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic [POS_W-1:0]  pos;
        logic              last;
        logic              ok;
        logic [SUM_W-1:0]  sum;
    } frame_result_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic [BYTE_W-1:0] rx_byte   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [BYTE_W-1:0] frame_byte;
    logic [POS_W-1:0]  byte_position;
    logic              last;
    logic              checksum_ok;
    logic [SUM_W-1:0]  computed_sum;

    logic              in_fire  = 1'b0;
    logic              out_fire = 1'b0;
    int                cycle_count = 0;
    int                error_count = 0;

    rx_item_t          rx_stream [$];
    frame_result_t     deframed_q [$];
    bit                drain_mark = 1'b0;
    bit                hold_mark  = 1'b0;

    logic [BYTE_W-1:0] shadow_store [FRAME_LEN];
    logic [5:0]        fill_pos    = '0;
    logic [SUM_W-1:0]  payload_sum = '0;

    int send_gap      = 0;
    int send_quiet    = 0;
    int recv_gap      = 0;
    int recv_quiet    = 0;
    int hold_left     = 0;
    int hold_requests = 0;
    int holds_seen    = 0;

    header_sync_frame_checksum_deframer_top #(
        .FRAME_LEN(FRAME_LEN)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .frame_byte   (frame_byte),
        .byte_position(byte_position),
        .last         (last),
        .checksum_ok  (checksum_ok),
        .computed_sum (computed_sum)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
        int               p;
        int               k;
        logic [SUM_W-1:0] trailer;
        frame_result_t    r;
        if (fill_pos >= FRAME_LEN)
            fill_pos = '0;
        if (fill_pos == 0)
        begin
            if (b == HDR0)
            begin
                shadow_store[0] = b;
                payload_sum = '0;
                fill_pos = 6'd1;
            end
        end
        else
        begin
            p = fill_pos;
            shadow_store[p] = b;
            if (p >= SUM_LO && p <= SUM_HI)
                payload_sum = payload_sum + SUM_W'(b);
            p++;
            if (p == HDR_LEN && (shadow_store[0] != HDR0 || shadow_store[1] != HDR1 ||
                                 shadow_store[2] != HDR2))
                fill_pos = '0;
            else if (p < FRAME_LEN)
                fill_pos = 6'(p);
            else
            begin
                fill_pos = '0;
                trailer = {shadow_store[FRAME_LEN-2], shadow_store[FRAME_LEN-1]};
                if (trailer != payload_sum)
                begin
                    r = '{data: '0, pos: '0, last: 1'b1, ok: 1'b0, sum: payload_sum};
                    deframed_q.push_back(r);
                end
                else
                begin
                    for (k = 0; k < FRAME_LEN; k++)
                    begin
                        r = '{data: shadow_store[k], pos: POS_W'(k), last: (k == FRAME_LEN - 1),
                              ok: 1'b1, sum: payload_sum};
                        deframed_q.push_back(r);
                    end
                end
            end
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    function automatic int pick_gap(inout int quiet);
        int r;
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            quiet = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void push_byte(input logic [BYTE_W-1:0] b);
        rx_item_t item;
        item.data  = b;
        item.drain = drain_mark;
        item.hold  = hold_mark;
        drain_mark = 1'b0;
        hold_mark  = 1'b0;
        rx_stream.push_back(item);
    endfunction

    function automatic void push_frame(input bit good_sum, input fill_t fill);
        logic [BYTE_W-1:0] b;
        logic [SUM_W-1:0]  s;
        int                i;
        s = '0;
        push_byte(HDR0);
        push_byte(HDR1);
        push_byte(HDR2);
        for (i = SUM_LO; i <= SUM_HI; i++)
        begin
            case (fill)
                FILL_ZERO: b = '0;
                FILL_ONES: b = '1;
                default:   b = BYTE_W'($urandom_range(0, 255));
            endcase
            s = s + SUM_W'(b);
            push_byte(b);
        end
        if (!good_sum)
            s = s ^ (SUM_W'(1) << $urandom_range(0, SUM_W - 1));
        push_byte(s[SUM_W-1:BYTE_W]);
        push_byte(s[BYTE_W-1:0]);
    endfunction

    always @(posedge clk)
    begin : scoreboard
        frame_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (deframed_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual byte 0x%0h pos %0d",
                             $time, frame_byte, byte_position);
                    error_count++;
                end
                else
                begin
                    want = deframed_q.pop_front();
                    check_field("frame_byte", want.data, frame_byte);
                    check_field("byte_position", want.pos, byte_position);
                    check_field("last", want.last, last);
                    check_field("checksum_ok", want.ok, checksum_ok);
                    check_field("computed_sum", want.sum, computed_sum);
                end
            end
            if (in_valid && in_ready)
                deframe_byte(rx_byte);
        end
        in_fire     <= rst_n && in_valid && in_ready;
        out_fire    <= rst_n && out_valid && out_ready;
        cycle_count <= cycle_count + 1;
    end

    always @(negedge clk)
    begin : sender
        rx_item_t          item;
        logic              next_valid;
        logic [BYTE_W-1:0] next_byte;
        next_valid = 1'b0;
        next_byte  = rx_byte;
        if (!rst_n)
            next_valid = 1'b0;
        else if (in_valid && !in_fire)
            next_valid = 1'b1;
        else if (send_gap > 0)
            send_gap--;
        else if (rx_stream.size() != 0 && !(rx_stream[0].drain && deframed_q.size() != 0))
        begin
            item = rx_stream.pop_front();
            if (item.hold)
                hold_requests <= hold_requests + 1;
            next_byte  = item.data;
            next_valid = 1'b1;
            send_gap   = pick_gap(send_quiet);
        end
        in_valid <= next_valid;
        rx_byte  <= next_byte;
    end

    always @(negedge clk)
    begin : receiver
        logic next_ready;
        if (hold_requests != holds_seen)
        begin
            holds_seen = hold_requests;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            next_ready = 1'b0;
        end
        else
        begin
            if (out_fire)
                recv_gap = pick_gap(recv_quiet);
            if (recv_gap > 0)
            begin
                recv_gap--;
                next_ready = 1'b0;
            end
            else
                next_ready = 1'b1;
        end
        out_ready <= next_ready;
    end

    initial
    begin : stimulus
        int                r;
        int                n;
        int                target;
        bit                drain_done;
        fill_t             fill;
        logic [BYTE_W-1:0] b;

        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(HDR1);
        push_byte(HDR2);
        push_byte(HDR0);
        push_byte(HDR1);
        push_byte(8'hFF);
        push_byte(HDR0);
        push_byte(8'h00);
        push_byte(HDR2);
        push_byte(HDR0);
        push_byte(HDR0);
        push_byte(HDR1);
        push_byte(HDR2);
        // The start byte that ends a bad header must not open a new frame.
        push_byte(HDR0);
        push_byte(HDR1);
        push_byte(HDR0);
        push_byte(HDR1);
        push_byte(HDR2);
        push_frame(1'b1, FILL_ZERO);
        push_frame(1'b1, FILL_ONES);
        push_frame(1'b0, FILL_RANDOM);

        target     = rx_stream.size() + RANDOM_ITEMS;
        drain_done = 1'b0;
        hold_mark  = 1'b1;
        while (rx_stream.size() < target)
        begin
            if (!drain_done && rx_stream.size() >= target - RANDOM_ITEMS / 2)
            begin
                drain_mark = 1'b1;
                drain_done = 1'b1;
            end
            r = $urandom_range(0, 99);
            n = $urandom_range(0, 99);
            if (n < 8)
                fill = FILL_ONES;
            else if (n < 12)
                fill = FILL_ZERO;
            else
                fill = FILL_RANDOM;
            if (r < 62)
                push_frame(1'b1, fill);
            else if (r < 78)
                push_frame(1'b0, fill);
            else if (r < 88)
            begin
                b = BYTE_W'($urandom_range(0, 255));
                push_byte(HDR0);
                case ($urandom_range(0, 2))
                    0:
                    begin
                        push_byte(HDR1);
                        push_byte((b == HDR2) ? ~b : b);
                    end
                    1:
                    begin
                        push_byte((b == HDR1) ? ~b : b);
                        push_byte(HDR2);
                    end
                    default:
                    begin
                        push_byte(HDR1);
                        push_byte(HDR0);
                    end
                endcase
            end
            else
            begin
                n = $urandom_range(1, 6);
                repeat (n) push_byte(BYTE_W'($urandom_range(0, 255)));
            end
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while ((rx_stream.size() != 0 || in_valid) && cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        while (deframed_q.size() != 0 && cycle_count < CYCLE_LIMIT)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (deframed_q.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, deframed_q.size());
            error_count += deframed_q.size();
        end

        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("header_sync_frame_checksum_deframer_top regression: fail");
        end
        else if (error_count == 0)
            $display("header_sync_frame_checksum_deframer_top regression: pass");
        else
            $display("header_sync_frame_checksum_deframer_top regression: fail");
        $finish;
    end

endmodule
